[rtl/core/far_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Function address relocator package
// Shared word types, command codes, control and status bundles.
// ----------------------------------------------------------------------------
package far_pkg;

    // Default table depth and reset value of the user space limit.
    localparam int          TABLE_DEPTH_DEFAULT = 1024;
    localparam logic [63:0] LIMIT_RESET         = 64'h0000_8000_0000_0000;

    // Command codes carried in the input word.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_EXACT  = 2'd1;
    localparam logic [1:0] CMD_RETURN = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  entry_index;
        logic [63:0] kernel_start;
        logic [63:0] user_start;
        logic [63:0] query_addr;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [63:0] result_addr;
        logic        hit;
        logic [9:0]  hit_index;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic scan_issue;
        logic scan_eval;
        logic fetch;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic bypass;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage : far_pkg
`default_nettype wire

[rtl/core/far_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Function address relocator controller
// Sequences the table clear, the table scan, the user entry fetch and the
// hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
module far_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire far_pkg::dp_status_t status,
    output far_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FETCH  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.bypass ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                cmd.scan_eval  = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : far_ctrl
`default_nettype wire

[rtl/core/far_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Function address relocator datapath
// Holds the kernel and user tables, the limit register, the scan pipeline,
// the best-match tracking and the output register.
// ----------------------------------------------------------------------------
module far_datapath #(
    parameter int TABLE_DEPTH = far_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wen,
    input  wire logic [63:0]         cfg_wdata,
    input  wire far_pkg::in_word_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output far_pkg::out_word_t       out_data,
    input  wire far_pkg::ctrl_cmd_t  cmd,
    output far_pkg::dp_status_t      status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    // Table memories.
    logic [63:0] kmem [TABLE_DEPTH];
    logic [63:0] umem [TABLE_DEPTH];

    logic [63:0]      limit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_valid_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic [63:0]      kdata_reg;
    logic [63:0]      udata_reg;
    logic             found_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [63:0]      best_reg;
    logic [63:0]      diff_reg;
    logic [1:0]       cmd_reg;
    logic [63:0]      q_reg;
    logic             out_valid_reg;
    far_pkg::out_word_t out_data_reg;
    far_pkg::out_word_t out_data_next;

    logic             idx_ok;
    logic             tbl_we;
    logic             k_we;
    logic [IDX_W-1:0] k_wa;
    logic [63:0]      k_wd;
    logic             issue_en;
    logic             is_exact;
    logic             k_zero;
    logic             exact_hit;
    logic             near_upd;
    logic             take_entry;

    // Write decode for table writes and the clearing pass.
    assign idx_ok = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);
    assign tbl_we = cmd.accept && (in_data.command == far_pkg::CMD_WRITE) && idx_ok;
    assign k_we   = cmd.clear_step || tbl_we;
    assign k_wa   = cmd.clear_step ? cnt_reg[IDX_W-1:0] : IDX_W'(in_data.entry_index);
    assign k_wd   = cmd.clear_step ? 64'd0 : in_data.kernel_start;

    // A scan read goes out while slots remain.
    assign issue_en = cmd.scan_issue && (cnt_reg < CNT_W'(TABLE_DEPTH));

    // Evaluation of the entry that came back from the kernel table.
    assign is_exact   = (cmd_reg == far_pkg::CMD_EXACT);
    assign k_zero     = (kdata_reg == 64'd0);
    assign exact_hit  = is_exact && !k_zero && (kdata_reg == q_reg);
    assign near_upd   = !is_exact && !k_zero && (kdata_reg <= q_reg)
                        && (!found_reg || (kdata_reg > best_reg));
    assign take_entry = cmd.scan_eval && pend_valid_reg && (exact_hit || near_upd);

    // Status toward the controller.
    assign status.clear_last = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign status.bypass     = ((in_data.command != far_pkg::CMD_EXACT)
                                && (in_data.command != far_pkg::CMD_RETURN))
                               || (in_data.query_addr <= limit_reg);
    assign status.scan_done  = pend_valid_reg
                               && (k_zero || exact_hit
                                   || (pidx_reg == IDX_W'(TABLE_DEPTH - 1)));
    assign status.out_free   = !out_valid_reg || out_ready;

    // Memory ports: one write and one registered read per table.
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            kmem[k_wa] <= k_wd;
        end
        if (issue_en)
        begin
            kdata_reg <= kmem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            umem[IDX_W'(in_data.entry_index)] <= in_data.user_start;
        end
        if (cmd.fetch)
        begin
            udata_reg <= umem[slot_reg];
        end
    end

    // Limit register; the user must write it only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= far_pkg::LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Scan control: slot counter, pending read flag, match flag and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cnt_reg        <= '0;
                pend_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.clear_step || issue_en)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (cmd.scan_issue)
                begin
                    pend_valid_reg <= issue_en;
                end
                if (take_entry)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the scan, the fetch and the output word.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= in_data.command;
            q_reg   <= in_data.query_addr;
        end
        if (issue_en)
        begin
            pidx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (take_entry)
        begin
            slot_reg <= pidx_reg;
            best_reg <= kdata_reg;
        end
        if (cmd.fetch)
        begin
            diff_reg <= q_reg - best_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Result word assembly.
    always_comb
    begin
        out_data_next = '0;
        if ((cmd_reg == far_pkg::CMD_EXACT) || (cmd_reg == far_pkg::CMD_RETURN))
        begin
            if (found_reg)
            begin
                out_data_next.hit         = 1'b1;
                out_data_next.hit_index   = 10'(slot_reg);
                out_data_next.result_addr = is_exact ? udata_reg : (udata_reg + diff_reg);
            end
            else
            begin
                out_data_next.result_addr = q_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : far_datapath
`default_nettype wire

[rtl/core/function_address_relocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Function address relocator
// Translates kernel-side function addresses to user-side addresses through
// two parallel tables of function starts.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one word per item:
//   a table write, an exact translate or a return-address translate. The
//   output channel (out_valid, out_ready, out_data) gives one word per item.
//   cfg_wen with cfg_wdata loads the user space limit; write it only while
//   no item is in flight.
//   A write or a passed-through query skips the scan and the fetch; its
//   result goes straight to the output register. A translate scans the
//   kernel table one slot per cycle from slot 0 through the single read port
//   of the kernel memory, stopping at a zero entry, at an exact hit, or after
//   the last slot; the user entry is then fetched and the result is loaded.
//   One item is worked on at a time; in_ready rises again the cycle after
//   its result is loaded into the output register. After reset the kernel
//   table is cleared one slot per cycle with in_ready low; the limit returns
//   to its default. If the receiver stalls, the result word holds in the
//   output register and the next item may be accepted, but its result waits
//   until the first word is taken.
// ----------------------------------------------------------------------------
module function_address_relocator_top #(
    parameter int TABLE_DEPTH = far_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wen,
    input  wire logic [63:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire far_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output far_pkg::out_word_t      out_data
);

    far_pkg::ctrl_cmd_t  cmd;
    far_pkg::dp_status_t status;

    // Controller.
    far_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    far_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    // A result is loaded only into a free output register.
    a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an untaken word");

    // The block goes busy right after it accepts a word.
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // A miss always reports slot zero.
    a_miss_index : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.hit_index == 10'd0))
        else $error("nonzero hit_index without a hit");
`endif

endmodule : function_address_relocator_top
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Function address relocator testbench
// Drives table writes, exact translates, return translates and the unused
// command code through the valid/ready input channel under several flow
// control modes and limit settings. A scoreboard keeps its own copy of both
// tables and the limit, predicts each result word and checks every output
// word in order.
// ----------------------------------------------------------------------------

// Tracks the relocation tables and the limit, and checks output words in order.
class relocation_scoreboard;
    logic [63:0]        kernel_starts [far_pkg::TABLE_DEPTH_DEFAULT];
    logic [63:0]        user_starts [far_pkg::TABLE_DEPTH_DEFAULT];
    logic [63:0]        user_limit;
    far_pkg::out_word_t predicted_relocations[$];
    int                 mismatches;
    int                 checked;
    int                 hits;

    function new();
        foreach (kernel_starts[i])
        begin
            kernel_starts[i] = '0;
            user_starts[i]   = '0;
        end
        user_limit  = far_pkg::LIMIT_RESET;
        mismatches  = 0;
        checked     = 0;
        hits        = 0;
    endfunction

    // Computes the result word of one input word and applies any table write.
    function far_pkg::out_word_t predict_translation(far_pkg::in_word_t w);
        far_pkg::out_word_t r;
        logic               found;
        logic [63:0]        best;
        logic [63:0]        k;
        int                 slot;
        int                 i;
        r     = '0;
        found = 1'b0;
        best  = '0;
        slot  = 0;
        case (w.command)
            far_pkg::CMD_WRITE:
            begin
                if (int'(w.entry_index) < far_pkg::TABLE_DEPTH_DEFAULT)
                begin
                    kernel_starts[w.entry_index] = w.kernel_start;
                    user_starts[w.entry_index]   = w.user_start;
                end
            end
            far_pkg::CMD_EXACT, far_pkg::CMD_RETURN:
            begin
                r.result_addr = w.query_addr;
                if (w.query_addr > user_limit)
                begin
                    // Scan from slot 0 up to the first zero kernel start.
                    for (i = 0; i < far_pkg::TABLE_DEPTH_DEFAULT; i++)
                    begin
                        k = kernel_starts[i];
                        if (k == '0)
                            break;
                        if (w.command == far_pkg::CMD_EXACT)
                        begin
                            if (k == w.query_addr)
                            begin
                                found = 1'b1;
                                slot  = i;
                                break;
                            end
                        end
                        else if (k <= w.query_addr && (!found || k > best))
                        begin
                            found = 1'b1;
                            best  = k;
                            slot  = i;
                        end
                    end
                    if (found)
                    begin
                        r.hit       = 1'b1;
                        r.hit_index = slot[9:0];
                        if (w.command == far_pkg::CMD_EXACT)
                            r.result_addr = user_starts[slot];
                        else
                            r.result_addr = user_starts[slot]
                                            + (w.query_addr - kernel_starts[slot]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Called for every input word accepted by the block.
    function void note_word(far_pkg::in_word_t w);
        predicted_relocations.push_back(predict_translation(w));
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Called for every output word taken from the block.
    task check_word(far_pkg::out_word_t got);
        far_pkg::out_word_t want;
        checked++;
        if (predicted_relocations.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got));
        end
        else
        begin
            want = predicted_relocations.pop_front();
            if (want.hit)
                hits++;
            if (got.result_addr !== want.result_addr)
                report_mismatch($sformatf("result_addr %h, predicted %h",
                                          got.result_addr, want.result_addr));
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit %b, predicted %b", got.hit, want.hit));
            if (got.hit_index !== want.hit_index)
                report_mismatch($sformatf("hit_index %0d, predicted %0d",
                                          got.hit_index, want.hit_index));
        end
    endtask
endclass

module testbench;

    localparam int          DEPTH        = far_pkg::TABLE_DEPTH_DEFAULT;
    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          PHASE_WORDS  = 70;
    localparam int          RANDOM_PHASES = 8;
    localparam logic [63:0] CLUSTER_BASE = 64'hFFFF_8000_0000_0000;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_mode_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_wen   = 1'b0;
    logic [63:0]        cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    far_pkg::in_word_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    far_pkg::out_word_t out_data;

    relocation_scoreboard sb;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;
    int          n_writes       = 0;
    int          n_exact        = 0;
    int          n_return       = 0;
    int          n_unused       = 0;
    logic [63:0] kernel_pool[$];

    function_address_relocator_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Output side: take words, check them, and stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_word(out_data);
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic far_pkg::in_word_t write_word(int idx, logic [63:0] k, logic [63:0] u);
        far_pkg::in_word_t w;
        w.command      = far_pkg::CMD_WRITE;
        w.entry_index  = idx[9:0];
        w.kernel_start = k;
        w.user_start   = u;
        w.query_addr   = rand64();
        return w;
    endfunction

    // Translate word; the fields a translate ignores carry random values.
    function automatic far_pkg::in_word_t query_word(logic [1:0] cmd, logic [63:0] q);
        far_pkg::in_word_t w;
        w.command      = cmd;
        w.entry_index  = 10'($urandom);
        w.kernel_start = rand64();
        w.user_start   = rand64();
        w.query_addr   = q;
        return w;
    endfunction

    function automatic logic [63:0] pool_pick();
        if (kernel_pool.size() == 0)
            return CLUSTER_BASE + 64'($urandom_range(0, 24'hFF_FFFF));
        return kernel_pool[$urandom_range(0, kernel_pool.size() - 1)];
    endfunction

    // Random word, weighted toward writes into a short table prefix and
    // translates aimed at kernel starts that were written.
    function automatic far_pkg::in_word_t random_word();
        far_pkg::in_word_t w;
        int                pick;
        int                idx;
        logic [63:0]       k;
        logic [63:0]       u;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                k = '0;
            else if (pick < 23)
                k = pool_pick();
            else if (pick < 35)
                k = rand64();
            else
                k = CLUSTER_BASE + 64'($urandom_range(0, 24'hFF_FFFF));
            u = ($urandom_range(0, 9) == 0) ? (64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 16'hFFFF)))
                                            : rand64();
            if (k != '0)
            begin
                kernel_pool.push_back(k);
                if (kernel_pool.size() > 64)
                    void'(kernel_pool.pop_front());
            end
            w = write_word(idx, k, u);
        end
        else if (pick < 60)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                w = query_word(far_pkg::CMD_EXACT, pool_pick());
            else if (pick < 80)
                w = query_word(far_pkg::CMD_EXACT, pool_pick() + 64'd1);
            else if (pick < 90)
                w = query_word(far_pkg::CMD_EXACT,
                               CLUSTER_BASE + 64'($urandom_range(0, 24'hFF_FFFF)));
            else
                w = query_word(far_pkg::CMD_EXACT, rand64());
        end
        else if (pick < 95)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                w = query_word(far_pkg::CMD_RETURN,
                               pool_pick() + 64'($urandom_range(0, 16'hFFFF)));
            else if (pick < 80)
                w = query_word(far_pkg::CMD_RETURN,
                               CLUSTER_BASE + 64'($urandom_range(0, 24'hFF_FFFF)));
            else
                w = query_word(far_pkg::CMD_RETURN, rand64());
        end
        else
        begin
            w = {far_pkg::CMD_UNUSED, 10'($urandom), rand64(), rand64(), rand64()};
        end
        return w;
    endfunction

    task automatic set_flow(flow_mode_t m);
        case (m)
            FLOW_FREE:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SENDER_IDLE:    begin send_idle_pct = 75; recv_stall_pct = 0;  end
            FLOW_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default:             begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // Offers one word, holding valid until the block takes it.
    task automatic send_word(far_pkg::in_word_t w);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(w);
        case (w.command)
            far_pkg::CMD_WRITE:  n_writes++;
            far_pkg::CMD_EXACT:  n_exact++;
            far_pkg::CMD_RETURN: n_return++;
            default:             n_unused++;
        endcase
    endtask

    // Drains all words in flight, then loads a new user space limit.
    task automatic set_limit(logic [63:0] value);
        in_valid <= 1'b0;
        while (sb.predicted_relocations.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        sb.user_limit = value;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_directed();
        localparam logic [63:0] KA = 64'hFFFF_8000_0010_0000;
        localparam logic [63:0] KB = 64'hFFFF_8000_0020_0000;
        localparam logic [63:0] KC = 64'hFFFF_8000_0030_0000;
        // Empty table: both searches miss.
        send_word(query_word(far_pkg::CMD_EXACT, KA));
        send_word(query_word(far_pkg::CMD_RETURN, ALL_ONES));
        // Short table with a duplicate start, a wrapping user start, and
        // the top slot written beyond the end marker.
        send_word(write_word(0, KA, 64'h0000_5555_0000_1000));
        send_word(write_word(1, KB, 64'h0000_5555_0000_2000));
        send_word(write_word(2, KA, 64'h0000_7777_0000_0000));
        send_word(write_word(3, KC, 64'hFFFF_FFFF_FFFF_FFF0));
        send_word(write_word(1023, ALL_ONES, ALL_ONES));
        send_word(query_word(far_pkg::CMD_EXACT, KA));
        send_word(query_word(far_pkg::CMD_EXACT, KB));
        send_word(query_word(far_pkg::CMD_EXACT, KC));
        send_word(query_word(far_pkg::CMD_EXACT, KB + 64'd1));
        send_word(query_word(far_pkg::CMD_RETURN, KA));
        send_word(query_word(far_pkg::CMD_RETURN, KB + 64'h123));
        send_word(query_word(far_pkg::CMD_RETURN, KC + 64'h40));
        send_word(query_word(far_pkg::CMD_RETURN, ALL_ONES));
        send_word(query_word(far_pkg::CMD_RETURN, KA - 64'd1));
        // Queries at and just above the limit, and zero.
        send_word(query_word(far_pkg::CMD_EXACT, far_pkg::LIMIT_RESET));
        send_word(query_word(far_pkg::CMD_RETURN, far_pkg::LIMIT_RESET + 64'd1));
        send_word(query_word(far_pkg::CMD_EXACT, '0));
        // Unused command code with all ones and with all zeros elsewhere.
        send_word('1);
        send_word({far_pkg::CMD_UNUSED, 10'd0, 64'd0, 64'd0, 64'd0});
        // A zero start in slot 2 cuts the table short.
        send_word(write_word(2, '0, '0));
        send_word(query_word(far_pkg::CMD_EXACT, KC));
        send_word(query_word(far_pkg::CMD_RETURN, ALL_ONES));
    endtask

    // Main sequence.
    initial
    begin
        logic [63:0] phase_limits[RANDOM_PHASES];
        int          p;
        sb = new();
        phase_limits = '{far_pkg::LIMIT_RESET, 64'd0, rand64(), ALL_ONES,
                         CLUSTER_BASE + 64'h80_0000, rand64(), 64'd0, far_pkg::LIMIT_RESET};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words run on the reset value of the limit.
        set_flow(FLOW_FREE);
        run_directed();

        // Random phases, each under its own limit and flow control mode.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            set_limit(phase_limits[p]);
            set_flow(flow_mode_t'(p % 4));
            repeat (PHASE_WORDS) send_word(random_word());
        end

        // Let the last words drain and watch for anything extra.
        in_valid <= 1'b0;
        while (sb.predicted_relocations.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        $display("Checked %0d result words (%0d hits) from %0d writes, %0d exact, %0d return",
                 sb.checked, sb.hits, n_writes, n_exact, n_return);
        $display("and %0d unused-code words; limits at reset, zero, all ones and random; %s",
                 n_unused, "four flow control modes.");
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/far_pkg.sv
rtl/core/far_ctrl.sv
rtl/core/far_datapath.sv
rtl/core/function_address_relocator_top.sv
dv/testbench.sv
